>>> hdl/fcm_pkg.sv
// fcm_pkg: shared types, codes and helpers for the fully connected layer MAC.
// No dependencies; used by fully_connected_layer_mac_top.
`timescale 1ns / 1ps

package fcm_pkg;

  // Default sizes
  localparam int IN_MAX_DEF    = 64;
  localparam int OUT_MAX_DEF   = 64;
  localparam int ACC_WIDTH_DEF = 48;

  // Input actions
  typedef enum logic [1:0] {
    ACT_WEIGHT = 2'd0,
    ACT_BIAS   = 2'd1,
    ACT_ELEM   = 2'd2,
    ACT_PRIOR  = 2'd3
  } fcm_action_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_IN_LENGTH   = 3'd0,
    REG_OUT_LENGTH  = 3'd1,
    REG_USE_BIAS    = 3'd2,
    REG_RELU_ENABLE = 3'd3,
    REG_ACCUM_MODE  = 3'd4
  } fcm_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_ISSUE,
    ST_DRAIN,
    ST_FIN
  } fcm_state_t;

  // Saturate a 32-bit signed value to Q8.8 (16 bits)
  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    logic [15:0] res;
    if (v > 32'sd32767) begin
      res = 16'h7FFF;
    end else if (v < -32'sd32768) begin
      res = 16'h8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

>>> hdl/fcm_ram.sv
// fcm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/fully_connected_layer_mac_top.sv
// fully_connected_layer_mac_top: fixed-point fully connected layer, one shared MAC.
// Depends on fcm_pkg and fcm_ram.
`timescale 1ns / 1ps

// Fully connected layer, Q8.8 weights and inputs, Q16.16 biases and results.
// Drive start with an item while busy is low; the transfer happens on that
// edge. Weight, bias and prior writes, and input elements without the last
// mark, leave busy low. An element marked last starts the computation: busy
// rises and one result per output neuron follows, in neuron order, each on
// out_neuron_index/out_neuron_value/out_last_result for exactly one cycle
// with out_valid high. The receiver cannot stall, so take every result as it
// appears. A single 16x16 multiplier and one ACC_WIDTH accumulator are shared
// over all neurons, which are worked one after another: each passes through a
// bias fetch, one MAC issue per input element, a drain of the read and product
// registers, and a finish. Busy falls as the last result is registered; the
// next item may be taken while that result is still on the outputs. Stores
// are not cleared after reset; write every weight, bias and prior the
// configuration reads before use.
module fully_connected_layer_mac_top #(
  parameter int IN_MAX    = fcm_pkg::IN_MAX_DEF,
  parameter int OUT_MAX   = fcm_pkg::OUT_MAX_DEF,
  parameter int ACC_WIDTH = fcm_pkg::ACC_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_slot_index,
  input  logic [31:0] in_data_value,
  input  logic        in_last_element,
  // result channel
  output logic        out_valid,
  output logic [5:0]  out_neuron_index,
  output logic [31:0] out_neuron_value,
  output logic        out_last_result,
  // configuration port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int WSIZE = IN_MAX * OUT_MAX;
  localparam int IW    = $clog2(IN_MAX > 1 ? IN_MAX : 2);
  localparam int OW    = $clog2(OUT_MAX > 1 ? OUT_MAX : 2);
  localparam int WA    = $clog2(WSIZE > 1 ? WSIZE : 2);
  localparam int AW    = ACC_WIDTH;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [6:0] in_length_r, out_length_r;
  logic       use_bias_r, relu_enable_r, accum_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_length_r   <= 7'd64;
      out_length_r  <= 7'd64;
      use_bias_r    <= 1'b1;
      relu_enable_r <= 1'b0;
      accum_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fcm_pkg::REG_IN_LENGTH:   in_length_r   <= cfg_data;
        fcm_pkg::REG_OUT_LENGTH:  out_length_r  <= cfg_data;
        fcm_pkg::REG_USE_BIAS:    use_bias_r    <= cfg_data[0];
        fcm_pkg::REG_RELU_ENABLE: relu_enable_r <= cfg_data[0];
        fcm_pkg::REG_ACCUM_MODE:  accum_mode_r  <= cfg_data[0];
        default: ;  // indexes beyond the register list are dropped
      endcase
    end
  end

  // Clamp lengths to 1..MAX and form the last index of each loop
  logic [31:0]   ni32, no32;
  logic [IW-1:0] ni_last;
  logic [OW-1:0] no_last;

  always_comb begin
    if (in_length_r == 7'd0) begin
      ni32 = 32'd1;
    end else if ({25'd0, in_length_r} > 32'(IN_MAX)) begin
      ni32 = 32'(IN_MAX);
    end else begin
      ni32 = {25'd0, in_length_r};
    end
    if (out_length_r == 7'd0) begin
      no32 = 32'd1;
    end else if ({25'd0, out_length_r} > 32'(OUT_MAX)) begin
      no32 = 32'(OUT_MAX);
    end else begin
      no32 = {25'd0, out_length_r};
    end
  end

  assign ni_last = IW'(ni32 - 32'd1);
  assign no_last = OW'(no32 - 32'd1);

  // ---------------------------------------------------------------------------
  // Input transfer and store writes
  // ---------------------------------------------------------------------------
  fcm_pkg::fcm_state_t state_r, state_nxt;

  logic        accept;
  logic        go;
  logic [15:0] data_q88;
  logic        wt_we, bias_we, vec_we, prior_we;

  assign busy     = (state_r != fcm_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign data_q88 = fcm_pkg::sat16(in_data_value);

  // Out-of-range writes are dropped; an element still counts for the last mark
  assign wt_we    = accept && (in_action == fcm_pkg::ACT_WEIGHT)
                    && ({20'd0, in_slot_index} < 32'(WSIZE));
  assign bias_we  = accept && (in_action == fcm_pkg::ACT_BIAS)
                    && ({20'd0, in_slot_index} < 32'(OUT_MAX));
  assign prior_we = accept && (in_action == fcm_pkg::ACT_PRIOR)
                    && ({20'd0, in_slot_index} < 32'(OUT_MAX));
  assign vec_we   = accept && (in_action == fcm_pkg::ACT_ELEM)
                    && ({20'd0, in_slot_index} < 32'(IN_MAX));
  assign go       = accept && (in_action == fcm_pkg::ACT_ELEM) && in_last_element;

  // ---------------------------------------------------------------------------
  // Sequencer counters and decoded controls
  // ---------------------------------------------------------------------------
  logic [OW-1:0] o_r;
  logic [IW-1:0] i_r;
  logic [WA-1:0] w_base_r;
  logic          rd_v_r, pr_v_r;

  logic issue_en, init_en, fin_en, last_issue, last_neuron;

  assign last_issue  = (i_r == ni_last);
  assign last_neuron = (o_r == no_last);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcm_pkg::ST_IDLE:  if (go) state_nxt = fcm_pkg::ST_BIAS;
      fcm_pkg::ST_BIAS:  state_nxt = fcm_pkg::ST_ISSUE;
      fcm_pkg::ST_ISSUE: if (last_issue) state_nxt = fcm_pkg::ST_DRAIN;
      fcm_pkg::ST_DRAIN: if (!rd_v_r) state_nxt = fcm_pkg::ST_FIN;
      fcm_pkg::ST_FIN:   state_nxt = last_neuron ? fcm_pkg::ST_IDLE : fcm_pkg::ST_BIAS;
      default:           state_nxt = fcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    issue_en = 1'b0;
    init_en  = 1'b0;
    fin_en   = 1'b0;
    case (state_r)
      fcm_pkg::ST_ISSUE: begin
        issue_en = 1'b1;
        init_en  = (i_r == '0);  // bias read data is valid on the first issue
      end
      fcm_pkg::ST_FIN: fin_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fcm_pkg::ST_IDLE;
      o_r      <= '0;
      i_r      <= '0;
      w_base_r <= '0;
      rd_v_r   <= 1'b0;
      pr_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue_en;
      pr_v_r  <= rd_v_r;
      if (go) begin
        o_r      <= '0;
        i_r      <= '0;
        w_base_r <= '0;
      end
      if (issue_en) begin
        i_r <= last_issue ? '0 : i_r + 1'b1;
      end
      if (fin_en) begin
        o_r      <= o_r + 1'b1;
        w_base_r <= w_base_r + WA'(IN_MAX);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------
  logic [15:0] wt_rdata, vec_rdata;
  logic [31:0] bias_rdata, prior_rdata;
  logic [WA-1:0] wt_raddr;

  assign wt_raddr = w_base_r + WA'(i_r);

  fcm_ram #(.WIDTH(16), .DEPTH(WSIZE)) u_weight_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (WA'(in_slot_index)),
    .wdata (data_q88),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  fcm_ram #(.WIDTH(32), .DEPTH(OUT_MAX)) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr (OW'(in_slot_index)),
    .wdata (in_data_value),
    .raddr (o_r),
    .rdata (bias_rdata)
  );

  fcm_ram #(.WIDTH(16), .DEPTH(IN_MAX)) u_vector_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (IW'(in_slot_index)),
    .wdata (data_q88),
    .raddr (i_r),
    .rdata (vec_rdata)
  );

  // Prior read address stays on the current neuron, so its data holds to the finish
  fcm_ram #(.WIDTH(32), .DEPTH(OUT_MAX)) u_prior_ram (
    .clk   (clk),
    .we    (prior_we),
    .waddr (OW'(in_slot_index)),
    .wdata (in_data_value),
    .raddr (o_r),
    .rdata (prior_rdata)
  );

  // ---------------------------------------------------------------------------
  // Shared MAC: product register, then saturating accumulate
  // ---------------------------------------------------------------------------
  logic signed [31:0]   p_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW:0]   acc_sum;
  logic signed [AW-1:0] acc_sat, acc_relu;
  logic signed [AW:0]   final_sum;
  logic [31:0]          final_sat;
  logic [AW-31:0]       final_top;

  assign acc_sum = {acc_r[AW-1], acc_r} + (AW+1)'(p_r);

  // Clip to ACC_WIDTH when the sum leaves its range
  always_comb begin
    if (acc_sum[AW] != acc_sum[AW-1]) begin
      acc_sat = acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[AW-1:0];
    end
  end

  assign acc_relu  = (relu_enable_r && acc_r[AW-1]) ? '0 : acc_r;
  assign final_sum = {acc_relu[AW-1], acc_relu}
                     + (accum_mode_r ? (AW+1)'($signed(prior_rdata)) : '0);
  assign final_top = final_sum[AW:31];

  // Clip to Q16.16
  always_comb begin
    if ((&final_top) || !(|final_top)) begin
      final_sat = final_sum[31:0];
    end else begin
      final_sat = final_sum[AW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      p_r <= $signed(vec_rdata) * $signed(wt_rdata);
    end
  end

  // The accumulator is model state: it resets to zero and keeps the last sum (ReLU applied at the finish)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (init_en) begin
      acc_r <= use_bias_r ? AW'($signed(bias_rdata)) : '0;
    end else if (pr_v_r) begin
      acc_r <= acc_sat;
    end else if (fin_en) begin
      acc_r <= acc_relu;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: one-cycle strobe
  // ---------------------------------------------------------------------------
  logic        out_valid_r, out_last_r;
  logic [5:0]  out_index_r;
  logic [31:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_en;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_en) begin
      out_index_r <= 6'(o_r);
      out_value_r <= final_sat;
      out_last_r  <= last_neuron;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_neuron_index = out_index_r;
  assign out_neuron_value = out_value_r;
  assign out_last_result  = out_valid_r && out_last_r;

`ifndef SYNTH
  // A result only follows a finish cycle
  a_out_after_fin : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == fcm_pkg::ST_FIN))
    else $error("result strobe without a finish cycle");

  // The issue counter never passes the vector length
  a_issue_bound : assert property (@(posedge clk) disable iff (!rst_n)
    issue_en |-> (i_r <= ni_last))
    else $error("issue counter beyond in_length");

  // No product is still in flight when the next neuron starts
  a_no_carry : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcm_pkg::ST_BIAS) |-> (!pr_v_r && !rd_v_r))
    else $error("MAC pipeline not drained at neuron start");

  // The finish cycle sees a fully accumulated sum
  a_fin_drained : assert property (@(posedge clk) disable iff (!rst_n)
    fin_en |-> (!pr_v_r && !rd_v_r))
    else $error("finish with MAC work pending");

  // Busy falls only on the last neuron
  a_busy_end : assert property (@(posedge clk) disable iff (!rst_n)
    (fin_en && !last_neuron) |=> busy)
    else $error("busy dropped before the last neuron");
`endif

endmodule
